FILE: design/acf_pkg.sv
// Shared types and constants of the ambient color follower.
// Used by every module of the block; depends on nothing else.
package acf_pkg;

    localparam int COUNT_W = 16;
    localparam int LEVEL_W = 8;
    localparam int GAIN_W  = 9;
    localparam int THR_W   = 8;

    localparam int IN_DATA_W  = 3 * COUNT_W;
    localparam int OUT_DATA_W = 4 * LEVEL_W;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_WHITE_ENABLE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GREY_THRESHOLD = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RED_GAIN       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GREEN_GAIN     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BLUE_GAIN      = 3'd4;

    localparam logic [THR_W-1:0]  RST_GREY_THRESHOLD = 8'd10;
    localparam logic [GAIN_W-1:0] RST_RED_GAIN       = 9'd256;
    localparam logic [GAIN_W-1:0] RST_GREEN_GAIN     = 9'd256;
    localparam logic [GAIN_W-1:0] RST_BLUE_GAIN      = 9'd179;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    // Entries of the queue of finished sample groups.
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              white_enable;
        logic [THR_W-1:0]  grey_threshold;
        logic [GAIN_W-1:0] red_gain;
        logic [GAIN_W-1:0] green_gain;
        logic [GAIN_W-1:0] blue_gain;
    } cfg_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [LEVEL_W-1:0] quot;
    } div_stat_t;

endpackage

FILE: design/acf_queue.sv
// Short queue of accumulated sample groups between the front and back parts.
// Depends on acf_pkg for the depth and the status struct.
module acf_queue import acf_pkg::*; #(
    parameter int W = 54
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output q_stat_t      stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [W-1:0]      mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

endmodule

FILE: design/acf_front.sv
// Front part: takes sample beats and adds them into per-channel sums.
// A finished group of sums goes into the queue. Depends on acf_pkg.
module acf_front import acf_pkg::*; #(
    parameter int NUM_AVG = 3,
    parameter int SUMW    = 18
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  q_stat_t              q_stat,
    output logic                 q_push,
    output logic [3*SUMW-1:0]    q_wdata
);

    localparam int CNT_W = $clog2(NUM_AVG + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [SUMW-1:0]  sum_reg  [3];
    logic [SUMW-1:0]  sum_next [3];
    logic             accept;
    logic             group_end;

    assign s_tready  = !q_stat.full;
    assign accept    = s_tvalid && s_tready;
    assign group_end = (cnt_reg == CNT_W'(NUM_AVG - 1));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum_next[k] = sum_reg[k] + SUMW'(s_tdata[k*COUNT_W +: COUNT_W]);
        end
    end

    assign q_push  = accept && group_end;
    assign q_wdata = {sum_next[2], sum_next[1], sum_next[0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            for (int k = 0; k < 3; k++) begin
                sum_reg[k] <= '0;
            end
        end else if (accept) begin
            if (group_end) begin
                cnt_reg <= '0;
                for (int k = 0; k < 3; k++) begin
                    sum_reg[k] <= '0;
                end
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
                for (int k = 0; k < 3; k++) begin
                    sum_reg[k] <= sum_next[k];
                end
            end
        end
    end

endmodule

FILE: design/acf_div.sv
// Shared serial divider for quotients known to fit in eight bits.
// One quotient bit per cycle; a zero divisor gives zero. Depends on acf_pkg.
module acf_div import acf_pkg::*; #(
    parameter int NW = 27,
    parameter int DW = 20
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output div_stat_t     stat
);

    localparam int SW    = (NW > DW + LEVEL_W - 1) ? NW : DW + LEVEL_W - 1;
    localparam int CNT_W = $clog2(LEVEL_W);

    logic [SW-1:0]      rem_reg;
    logic [SW-1:0]      dsh_reg;
    logic [LEVEL_W-1:0] quot_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               zero_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               fits;

    assign fits = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= SW'(num);
            dsh_reg  <= SW'(den) << (LEVEL_W - 1);
            quot_reg <= '0;
            cnt_reg  <= CNT_W'(LEVEL_W - 1);
            zero_reg <= (den == '0);
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quot_reg <= {quot_reg[LEVEL_W-2:0], fits};
            dsh_reg  <= dsh_reg >> 1;
            cnt_reg  <= cnt_reg - 1'b1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.quot = zero_reg ? '0 : quot_reg;

endmodule

FILE: design/acf_back.sv
// Back part: turns one group of sums into a target color and plays the ramp.
// Sequencer around the shared divider and the output register. Depends on
// acf_pkg and acf_div.
module acf_back import acf_pkg::*; #(
    parameter int SUMW  = 18,
    parameter int STEPS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic [3*SUMW-1:0]     q_rdata,
    input  q_stat_t               q_stat,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    localparam int NW     = SUMW + 9;
    localparam int DW     = SUMW + 2;
    localparam int STEP_W = $clog2(STEPS + 1);

    // Division by STEPS is a multiply by the rounded-up reciprocal; it is exact
    // for eight-bit magnitudes and any STEPS up to 64.
    localparam int RECIP_SH = 16;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = LEVEL_W + RECIP_W;
    localparam logic [RECIP_W-1:0] STEP_RECIP = RECIP_W'((2 ** RECIP_SH + STEPS - 1) / STEPS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOTAL,
        ST_NORM,
        ST_NORM_WAIT,
        ST_RANGE,
        ST_SELECT,
        ST_STRETCH,
        ST_STRETCH_WAIT,
        ST_DELTA,
        ST_RAMP
    } state_t;

    state_t                    state_reg;
    logic [1:0]                ch_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [SUMW-1:0]           sums_reg [3];
    logic [DW-1:0]             total_reg;
    logic [LEVEL_W-1:0]        c_reg    [3];
    logic [LEVEL_W-1:0]        hi_reg;
    logic [LEVEL_W-1:0]        lo_reg;
    logic [LEVEL_W-1:0]        tgt_reg  [4];
    logic [LEVEL_W-1:0]        prev_reg [4];
    logic [LEVEL_W-1:0]        acc_reg  [4];
    logic signed [LEVEL_W:0]   inc_reg  [4];
    logic                      m_tvalid_reg;
    logic [OUT_DATA_W-1:0]     m_tdata_reg;
    logic                      m_tlast_reg;

    logic                      div_start;
    logic [NW-1:0]             div_num;
    logic [DW-1:0]             div_den;
    div_stat_t                 div_stat;
    logic [LEVEL_W-1:0]        span;
    logic signed [LEVEL_W:0]   delta;
    logic [LEVEL_W-1:0]        delta_mag;
    logic [PROD_W-1:0]         recip_prod;
    logic [LEVEL_W-1:0]        step_inc;
    logic [LEVEL_W-1:0]        step_val [4];
    logic [LEVEL_W-1:0]        gained   [3];
    logic [GAIN_W-1:0]         gain_sel [3];
    logic                      load_beat;

    acf_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .stat    (div_stat)
    );

    assign span      = c_reg[ch_reg] - lo_reg;
    assign delta     = $signed({1'b0, tgt_reg[ch_reg]}) - $signed({1'b0, prev_reg[ch_reg]});
    assign delta_mag = delta[LEVEL_W] ? LEVEL_W'(-delta) : delta[LEVEL_W-1:0];

    assign recip_prod = PROD_W'(delta_mag) * PROD_W'(STEP_RECIP);
    assign step_inc   = recip_prod[RECIP_SH +: LEVEL_W];

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            ST_NORM: begin
                div_start = 1'b1;
                div_num   = (NW'(sums_reg[ch_reg]) << LEVEL_W) - NW'(sums_reg[ch_reg]);
                div_den   = total_reg;
            end
            ST_STRETCH: begin
                div_start = 1'b1;
                div_num   = (NW'(span) << LEVEL_W) - NW'(span);
                div_den   = DW'(hi_reg);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // Each step adds the per-step increment; the sum always stays in range.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            step_val[k] = acc_reg[k] + inc_reg[k][LEVEL_W-1:0];
        end
    end

    assign gain_sel[0] = cfg.red_gain;
    assign gain_sel[1] = cfg.green_gain;
    assign gain_sel[2] = cfg.blue_gain;

    always_comb begin
        logic [LEVEL_W+GAIN_W-1:0] prod;
        for (int k = 0; k < 3; k++) begin
            prod = (LEVEL_W + GAIN_W)'(step_val[k]) * (LEVEL_W + GAIN_W)'(gain_sel[k]);
            if (prod[LEVEL_W+GAIN_W-1:LEVEL_W] > GAIN_W'(LEVEL_MAX)) begin
                gained[k] = LEVEL_MAX;
            end else begin
                gained[k] = prod[2*LEVEL_W-1:LEVEL_W];
            end
        end
    end

    assign q_pop     = (state_reg == ST_IDLE) && !q_stat.empty;
    assign load_beat = (state_reg == ST_RAMP) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ch_reg       <= '0;
            step_reg     <= STEP_W'(1);
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                prev_reg[k] <= '0;
                tgt_reg[k]  <= '0;
            end
        end else begin
            if (load_beat) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_stat.empty) begin
                        for (int k = 0; k < 3; k++) begin
                            sums_reg[k] <= q_rdata[k*SUMW +: SUMW];
                        end
                        state_reg <= ST_TOTAL;
                    end
                end
                ST_TOTAL: begin
                    total_reg <= DW'(sums_reg[0]) + DW'(sums_reg[1]) + DW'(sums_reg[2]);
                    ch_reg    <= '0;
                    state_reg <= ST_NORM;
                end
                ST_NORM: begin
                    state_reg <= ST_NORM_WAIT;
                end
                ST_NORM_WAIT: begin
                    if (div_stat.done) begin
                        c_reg[ch_reg] <= div_stat.quot;
                        if (ch_reg == 2'd2) begin
                            state_reg <= ST_RANGE;
                        end else begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= ST_NORM;
                        end
                    end
                end
                ST_RANGE: begin
                    // Largest and smallest of the three normalized channels.
                    hi_reg <= (c_reg[0] >= c_reg[1])
                              ? ((c_reg[0] >= c_reg[2]) ? c_reg[0] : c_reg[2])
                              : ((c_reg[1] >= c_reg[2]) ? c_reg[1] : c_reg[2]);
                    lo_reg <= (c_reg[0] <= c_reg[1])
                              ? ((c_reg[0] <= c_reg[2]) ? c_reg[0] : c_reg[2])
                              : ((c_reg[1] <= c_reg[2]) ? c_reg[1] : c_reg[2]);
                    state_reg <= ST_SELECT;
                end
                ST_SELECT: begin
                    ch_reg <= '0;
                    if (cfg.white_enable && (hi_reg - lo_reg) < cfg.grey_threshold) begin
                        tgt_reg[0] <= '0;
                        tgt_reg[1] <= '0;
                        tgt_reg[2] <= '0;
                        tgt_reg[3] <= hi_reg;
                        state_reg  <= ST_DELTA;
                    end else begin
                        state_reg <= ST_STRETCH;
                    end
                end
                ST_STRETCH: begin
                    state_reg <= ST_STRETCH_WAIT;
                end
                ST_STRETCH_WAIT: begin
                    if (div_stat.done) begin
                        tgt_reg[ch_reg] <= div_stat.quot;
                        if (ch_reg == 2'd2) begin
                            tgt_reg[3] <= '0;
                            ch_reg     <= '0;
                            state_reg  <= ST_DELTA;
                        end else begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= ST_STRETCH;
                        end
                    end
                end
                ST_DELTA: begin
                    inc_reg[ch_reg] <= delta[LEVEL_W]
                                       ? -$signed({1'b0, step_inc})
                                       : $signed({1'b0, step_inc});
                    acc_reg[ch_reg] <= prev_reg[ch_reg];
                    if (ch_reg == 2'd3) begin
                        step_reg  <= STEP_W'(1);
                        state_reg <= ST_RAMP;
                    end else begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                ST_RAMP: begin
                    if (load_beat) begin
                        for (int k = 0; k < 4; k++) begin
                            acc_reg[k] <= step_val[k];
                        end
                        m_tdata_reg  <= {step_val[3], gained[2], gained[1], gained[0]};
                        m_tlast_reg  <= (step_reg == STEP_W'(STEPS));
                        if (step_reg == STEP_W'(STEPS)) begin
                            for (int k = 0; k < 4; k++) begin
                                prev_reg[k] <= tgt_reg[k];
                            end
                            state_reg <= ST_IDLE;
                        end else begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: design/ambient_color_follow.sv
// Ambient color follower. Sample beats on s_* carry raw red, green and blue
// sensor counts (s_tdata: red_count, green_count, blue_count, from bit 0).
// Every NUM_AVG samples the sums become a new target color and STEPS beats
// leave on m_* that ramp from the previous color toward it (m_tdata:
// red_level, green_level, blue_level, white_level; m_tlast marks the final
// step). Red, green and blue carry their Q1.8 gains from the APB registers.
// The front accepts one sample per cycle while the two-entry queue of sample
// groups has room. The back handles one group at a time: three normalizing
// and three stretching divisions through one serial divider, then the
// per-step increments of the four levels. When white mode picks a grey
// color the stretch is skipped. Once the first ramp beat is loaded, the ramp
// gives one beat per cycle while m_tready is high; when m_tready is low the
// ramp waits in the output register, and once the queue fills s_tready
// drops. Reset clears the sums, the sample count, the previous and target
// colors, and loads the register defaults. Depends on acf_pkg, acf_front,
// acf_queue, acf_div and acf_back.
module ambient_color_follow import acf_pkg::*; #(
    parameter int NUM_AVG = 3,
    parameter int STEPS   = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // red_count, green_count, blue_count
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // red, green, blue, white level
    output logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SUMW = COUNT_W + ((NUM_AVG > 1) ? $clog2(NUM_AVG) : 0);

    cfg_t                 cfg_reg;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 q_push;
    logic                 q_pop;
    logic [3*SUMW-1:0]    q_wdata;
    logic [3*SUMW-1:0]    q_rdata;
    q_stat_t              q_stat;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.white_enable   <= 1'b0;
            cfg_reg.grey_threshold <= RST_GREY_THRESHOLD;
            cfg_reg.red_gain       <= RST_RED_GAIN;
            cfg_reg.green_gain     <= RST_GREEN_GAIN;
            cfg_reg.blue_gain      <= RST_BLUE_GAIN;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_WHITE_ENABLE:   cfg_reg.white_enable   <= pwdata[0];
                REG_GREY_THRESHOLD: cfg_reg.grey_threshold <= pwdata[THR_W-1:0];
                REG_RED_GAIN:       cfg_reg.red_gain       <= pwdata[GAIN_W-1:0];
                REG_GREEN_GAIN:     cfg_reg.green_gain     <= pwdata[GAIN_W-1:0];
                REG_BLUE_GAIN:      cfg_reg.blue_gain      <= pwdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WHITE_ENABLE:   prdata = APB_DATA_W'(cfg_reg.white_enable);
            REG_GREY_THRESHOLD: prdata = APB_DATA_W'(cfg_reg.grey_threshold);
            REG_RED_GAIN:       prdata = APB_DATA_W'(cfg_reg.red_gain);
            REG_GREEN_GAIN:     prdata = APB_DATA_W'(cfg_reg.green_gain);
            REG_BLUE_GAIN:      prdata = APB_DATA_W'(cfg_reg.blue_gain);
            default:            prdata = '0;
        endcase
    end

    acf_front #(
        .NUM_AVG (NUM_AVG),
        .SUMW    (SUMW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    acf_queue #(
        .W (3 * SUMW)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    acf_back #(
        .SUMW  (SUMW),
        .STEPS (STEPS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_rdata  (q_rdata),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The front never pushes a group into a full queue.
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("group pushed into a full queue");

    // The back only pops a group that is there.
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("group popped from an empty queue");

    // After the final ramp beat is taken, the next ramp needs a full recompute.
    a_gap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("beat follows the final ramp step without a recompute");

endmodule
